### rtl/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

  // sync classes
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_J    = 2'd1;
  localparam logic [1:0] CLASS_K    = 2'd2;

  // request types
  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  localparam logic [7:0]  SWEEP_LIMIT_RESET = 8'd50;
  localparam logic [31:0] BAD_WIDTH         = 32'd140;
  localparam logic [7:0]  NO_SWEEP_LIMIT    = 8'd60;
  localparam logic [7:0]  NO_SWEEP_MAX      = 8'd255;

  // width band edges
  localparam logic [31:0] BAND_LO      = 32'd74;
  localparam logic [31:0] BAND_A_LO    = 32'd83;
  localparam logic [31:0] BAND_A_HI_K  = 32'd95;
  localparam logic [31:0] BAND_A_HI_J  = 32'd93;
  localparam logic [31:0] BAND_B_LO    = 32'd106;
  localparam logic [31:0] BAND_B_HI    = 32'd117;
  localparam logic [31:0] BAND_C_LO    = 32'd127;
  localparam logic [31:0] BAND_C_HI    = 32'd137;

  typedef struct packed {
    logic        req_type;
    logic        edge_rising;
    logic [31:0] edge_time_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] x_average;
    logic [15:0] y_average;
    logic [1:0]  sync_class;
    logic        receiving;
    logic        x_updated;
    logic        y_updated;
  } out_item_t;

  // what one processed word does to the rings and the status
  typedef struct packed {
    logic        x_store;
    logic        y_store;
    logic [15:0] sample;
    logic [1:0]  sync_class;
    logic        receiving;
  } pulse_t;

  function automatic logic in_gap_band(logic [31:0] w, logic [31:0] mid_hi);
    return (w < BAND_LO) || ((w > BAND_A_LO) && (w < mid_hi)) ||
           ((w > BAND_B_LO) && (w < BAND_B_HI)) ||
           ((w > BAND_C_LO) && (w < BAND_C_HI));
  endfunction

endpackage

### rtl/lpd_chan_if.sv
`timescale 1ns / 1ps

interface lpd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lighthouse_pulse_position_decoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Word                                   Handshake
// in_i     in   req_type, edge_rising, edge_time_us    valid / ready
// out_o    out  x/y_average, sync_class, receiving,    valid / ready
//               x_updated, y_updated
// cfg_i    in   sweep_width_limit (8 bits)             valid / ready (always ready)
//
// One word per cycle sustained while out_o is ready; in_q feeds result register out_q.
// Each cycle's work is one edge decode plus a running-sum update and a reciprocal
// multiply for each ring average, between the input register and the result register.
// Reset is asynchronous, active low; all state but the input and result data registers
// comes up at once, with receiving set and sweep_width_limit at 50.
// A stalled result holds in the result register while the input register still
// takes a word; the input side stalls only when both are full.

module lighthouse_pulse_position_decoder #(
  parameter int AVG_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpd_chan_if.sink   in_i,
  lpd_chan_if.source out_o,
  lpd_chan_if.sink   cfg_i
);
  import lpd_pkg::*;

  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic [7:0] sweep_limit_q;

  logic       advance;
  pulse_t     pulse;
  logic [15:0] x_avg;
  logic [15:0] y_avg;

  // advance the input word when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_limit_q <= SWEEP_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      sweep_limit_q <= cfg_i.data;
    end
  end

  lpd_edge_ctrl u_edge_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .item_i        (in_q),
    .sweep_limit_i (sweep_limit_q),
    .pulse_o       (pulse)
  );

  lpd_ring_avg #(.AVG_DEPTH(AVG_DEPTH)) u_x_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .store_i  (pulse.x_store),
    .sample_i (pulse.sample),
    .avg_o    (x_avg)
  );

  lpd_ring_avg #(.AVG_DEPTH(AVG_DEPTH)) u_y_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .store_i  (pulse.y_store),
    .sample_i (pulse.sample),
    .avg_o    (y_avg)
  );

  always_comb begin
    out_d.x_average  = x_avg;
    out_d.y_average  = y_avg;
    out_d.sync_class = pulse.sync_class;
    out_d.receiving  = pulse.receiving;
    out_d.x_updated  = pulse.x_store;
    out_d.y_updated  = pulse.y_store;
  end

  // hold the result until taken; drop valid when drained with nothing behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### rtl/lpd_edge_ctrl.sv
`timescale 1ns / 1ps

module lpd_edge_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lpd_pkg::in_item_t item_i,
  input  logic [7:0]        sweep_limit_i,
  output lpd_pkg::pulse_t   pulse_o
);
  import lpd_pkg::*;

  logic [31:0] rise_q, rise_d;
  logic [31:0] prev_fall_q, prev_fall_d;
  logic [1:0]  class_q, class_d;
  logic [7:0]  count_q, count_d;
  logic        recv_q, recv_d;

  logic [31:0] width;
  logic        process;
  logic        is_sweep;
  logic [7:0]  count_base;

  assign width    = item_i.edge_time_us - rise_q;
  assign is_sweep = width <= {24'd0, sweep_limit_i};
  assign process  = en_i && (item_i.req_type == REQ_EDGE) && !item_i.edge_rising &&
                    recv_q && (item_i.edge_time_us != prev_fall_q);
  assign count_base = is_sweep ? 8'd0 : count_q;

  always_comb begin
    rise_d      = rise_q;
    prev_fall_d = prev_fall_q;
    class_d     = class_q;
    count_d     = count_q;
    recv_d      = recv_q;
    if (en_i && (item_i.req_type == REQ_RESTART)) begin
      recv_d = 1'b1;
    end else if (en_i && item_i.edge_rising) begin
      rise_d = item_i.edge_time_us;
    end else if (process) begin
      if (!is_sweep) begin
        if (width > BAD_WIDTH) begin
          class_d = CLASS_NONE;
        end else if (!in_gap_band(width, BAND_A_HI_K)) begin
          class_d = CLASS_K;
        end else if (in_gap_band(width, BAND_A_HI_J)) begin
          class_d = CLASS_J;
        end
      end
      if (count_base > NO_SWEEP_LIMIT) begin
        recv_d = 1'b0;
      end
      count_d     = (count_base == NO_SWEEP_MAX) ? NO_SWEEP_MAX : count_base + 8'd1;
      prev_fall_d = item_i.edge_time_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= '0;
      prev_fall_q <= '0;
      class_q     <= CLASS_NONE;
      count_q     <= '0;
      recv_q      <= 1'b1;
    end else begin
      rise_q      <= rise_d;
      prev_fall_q <= prev_fall_d;
      class_q     <= class_d;
      count_q     <= count_d;
      recv_q      <= recv_d;
    end
  end

  // a sweep stores under the class seen before it
  assign pulse_o.x_store    = process && is_sweep && (class_q == CLASS_K);
  assign pulse_o.y_store    = process && is_sweep && (class_q == CLASS_J);
  assign pulse_o.sample     = rise_q[15:0] - prev_fall_q[15:0];
  assign pulse_o.sync_class = class_d;
  assign pulse_o.receiving  = recv_d;

endmodule

### rtl/lpd_ring_avg.sv
`timescale 1ns / 1ps

module lpd_ring_avg #(
  parameter int AVG_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        store_i,
  input  logic [15:0] sample_i,
  output logic [15:0] avg_o
);
  localparam int DIV_L  = $clog2(AVG_DEPTH);
  localparam int SLOT_W = (DIV_L > 0) ? DIV_L : 1;
  localparam int SUM_W  = 16 + DIV_L;
  localparam int MUL_S  = SUM_W + DIV_L;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);
  // ceil(2^MUL_S / depth): exact quotient for every SUM_W-bit sum
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << MUL_S) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  logic [15:0]       ring_q [AVG_DEPTH];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [2*SUM_W:0]  product;

  // keep a running sum: add the new sample, drop the one it replaces
  always_comb begin
    slot_d = slot_q;
    sum_d  = sum_q;
    if (store_i) begin
      sum_d  = sum_q + SUM_W'(sample_i) - SUM_W'(ring_q[slot_q]);
      slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  assign product = (2*SUM_W+1)'(sum_d) * (2*SUM_W+1)'(RECIP);
  assign avg_o   = product[MUL_S +: 16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sum_q  <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      slot_q <= slot_d;
      sum_q  <= sum_d;
      if (store_i) begin
        ring_q[slot_q] <= sample_i;
      end
    end
  end

endmodule

### rtl/lpd_checker.sv
`timescale 1ns / 1ps

module lpd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input lpd_pkg::out_item_t out_data_i
);
  import lpd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // an X sample comes only from a sweep after K while receiving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.x_updated |->
      (out_data_i.sync_class == CLASS_K) && out_data_i.receiving)
    else $error("X update without K sync or receiving");

  // a Y sample comes only from a sweep after J while receiving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.y_updated |->
      (out_data_i.sync_class == CLASS_J) && out_data_i.receiving)
    else $error("Y update without J sync or receiving");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.sync_class == CLASS_NONE) ||
      (out_data_i.sync_class == CLASS_J) || (out_data_i.sync_class == CLASS_K))
    else $error("undefined sync class");

endmodule

bind lighthouse_pulse_position_decoder lpd_checker u_lpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
